FILE: rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and constants shared by the bitmap frame allocator files.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FRAME_W = 13;   // frame counts, 0..8191
  localparam int IDX_W   = 12;   // frame number on the ports
  localparam int BASE_W  = 14;   // frame number of a word's bit 0, plus one word
  localparam int OFF_W   = 15;   // signed offsets against a word base

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_LOCK    = 2'd1,
    MODE_RESERVE = 2'd2,
    MODE_RELEASE = 2'd3
  } bfa_mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_MARK
  } bfa_state_t;

  typedef struct packed {
    bfa_mode_t          mode;
    logic [IDX_W-1:0]   first_frame;
    logic [FRAME_W-1:0] run_len;
  } bfa_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   granted_frame;
    logic               ok;
    logic [FRAME_W-1:0] free_frames;
    logic [FRAME_W-1:0] os_frames;
    logic [FRAME_W-1:0] hw_frames;
  } bfa_rsp_t;

endpackage

FILE: rtl/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bitmap_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core
// Page frame allocator: one used bit per frame in a word-wide RAM, first-fit
// search for contiguous free runs, free / OS / hardware frame counters.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (req) is taken when start is high and busy is low. Exactly
//   one response word (rsp) follows, shown for one cycle with done high; the
//   receiver cannot hold it off. The next request may be issued in the cycle
//   done is high.
//   Invalid requests (zero count, range past frames_in_use, allocate larger
//   than frames_in_use) answer in the cycle after start with ok low.
//   Lock, reserve and release sweep the bitmap from word 0 up to the word that
//   holds the range end. Allocate first scans one word per cycle until the run
//   is found (or the last managed word is passed), then marks the run with the
//   same sweep. The rate is set by the RAM, with one read and one write port:
//   one bitmap word per cycle.
//   cfg_we writes frames_in_use (clamped to NUM_FRAMES) and reloads the free
//   counter; write it only while idle.
//   After reset the bitmap is cleared, one word per cycle, with busy held high.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_core #(
  parameter int NUM_FRAMES = 4096,
  parameter int WORD_BITS  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bfa_pkg::bfa_req_t req,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_data,
  output logic              done,
  output bfa_pkg::bfa_rsp_t rsp
);

  import bfa_pkg::*;

  localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LV    = $clog2(WORD_BITS + 1) - 1;   // floor(log2(WORD_BITS))
  localparam int LVW   = $clog2(LV + 1);
  localparam int OW    = $clog2(WORD_BITS + 1);
  localparam int PW    = $clog2(WORD_BITS);
  localparam int FMAX  = (NUM_FRAMES < 8191) ? NUM_FRAMES : 8191;
  localparam int FRST  = (FMAX < 4096) ? FMAX : 4096;

  localparam logic [FRAME_W-1:0] FRAMES_MAX = FRAME_W'(FMAX);
  localparam logic [FRAME_W-1:0] FRAMES_RST = FRAME_W'(FRST);
  localparam logic [BASE_W-1:0]  WORD_STEP  = BASE_W'(WORD_BITS);
  localparam logic [AW-1:0]      LAST_WORD  = AW'(WORDS - 1);

  bfa_state_t state, state_next;

  logic [AW-1:0]      cur_addr;
  logic [BASE_W-1:0]  cur_base;
  logic [FRAME_W-1:0] carry;
  logic [FRAME_W-1:0] lo;
  logic [BASE_W-1:0]  hi;
  logic [FRAME_W-1:0] n_req;
  bfa_mode_t          mode_r;
  logic [IDX_W-1:0]   first_r;
  logic [FRAME_W-1:0] fiu;
  logic [FRAME_W-1:0] free_cnt;
  logic [FRAME_W-1:0] os_cnt;
  logic [FRAME_W-1:0] hw_cnt;

  // RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] rd_data;

  bfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  function automatic logic [FRAME_W-1:0] sat_add(input logic [FRAME_W-1:0] c,
                                                 input logic [FRAME_W-1:0] n,
                                                 input logic [FRAME_W-1:0] lim);
    logic [FRAME_W:0] s;
    s = {1'b0, c} + {1'b0, n};
    return (s > {1'b0, lim}) ? lim : s[FRAME_W-1:0];
  endfunction

  function automatic logic [FRAME_W-1:0] sat_sub(input logic [FRAME_W-1:0] c,
                                                 input logic [FRAME_W-1:0] n);
    return (n >= c) ? '0 : c - n;
  endfunction

  // --------------------------------------------------------------------------
  // Request checks
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0] req_end;
  logic              req_valid;

  always_comb begin
    req_end = {2'b0, req.first_frame} + {1'b0, req.run_len};
    if (req.run_len == '0) begin
      req_valid = 1'b0;
    end else if (req.mode == MODE_ALLOC) begin
      req_valid = (req.run_len <= fiu);
    end else begin
      req_valid = (req_end <= {1'b0, fiu});
    end
  end

  // --------------------------------------------------------------------------
  // Search over one word
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0]    elig_lim;
  logic [WORD_BITS-1:0] free_w;
  logic [WORD_BITS-1:0] dbl [LV+1];
  logic [LVW-1:0]       lvl;
  logic [OW-1:0]        win_sh;
  logic                 n_small;
  logic [WORD_BITS-1:0] win;
  logic [WORD_BITS-1:0] pf;
  logic [WORD_BITS-1:0] thr_ok;
  logic [WORD_BITS-1:0] hit;
  logic signed [OFF_W-1:0] thr_t;
  logic                 hit_any;
  logic [PW-1:0]        hit_pos;
  logic [BASE_W-1:0]    granted_c;
  logic [PW-1:0]        last_used;
  logic [OW-1:0]        lead_free;
  logic [BASE_W-1:0]    carry_sum;
  logic [FRAME_W-1:0]   carry_next;
  logic [BASE_W-1:0]    next_base;
  logic                 last_s;
  logic                 last_m;

  always_comb begin
    elig_lim = {1'b0, fiu} - cur_base;
    for (int b = 0; b < WORD_BITS; b++) begin
      free_w[b] = (BASE_W'(b) < elig_lim) && !rd_data[b];
    end

    // dbl[j][p]: frames p-2^j+1 .. p all free
    dbl[0] = free_w;
    for (int j = 1; j <= LV; j++) begin
      dbl[j] = dbl[j-1] & (dbl[j-1] << (1 << (j - 1)));
    end

    // run of n inside the word: two overlapping power-of-two windows
    lvl = '0;
    for (int j = 0; j <= LV; j++) begin
      if (n_req[j]) begin
        lvl = LVW'(j);
      end
    end
    n_small = (n_req <= FRAME_W'(WORD_BITS));
    win_sh  = n_req[OW-1:0] - (OW'(1) << lvl);
    win     = n_small ? (dbl[lvl] & (dbl[lvl] << win_sh)) : '0;

    // run that starts in earlier words and ends at p
    thr_t = OFF_W'({2'b0, n_req}) - OFF_W'({2'b0, carry}) - OFF_W'(1);
    for (int p = 0; p < WORD_BITS; p++) begin
      pf[p]     = ((~free_w) & ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - p))) == '0;
      thr_ok[p] = $signed(OFF_W'(p)) >= thr_t;
    end
    hit = win | (pf & thr_ok);

    hit_any = |hit;
    hit_pos = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (hit[p]) begin
        hit_pos = PW'(p);
      end
    end
    granted_c = cur_base + BASE_W'(hit_pos) + BASE_W'(1) - {1'b0, n_req};

    // free frames at the top of the word carry into the next one
    last_used = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!free_w[b]) begin
        last_used = PW'(b);
      end
    end
    lead_free = OW'(WORD_BITS - 1) - OW'(last_used);
    carry_sum = {1'b0, carry} + WORD_STEP;
    if (&free_w) begin
      carry_next = (carry_sum > {1'b0, FRAMES_MAX}) ? FRAMES_MAX : carry_sum[FRAME_W-1:0];
    end else begin
      carry_next = FRAME_W'(lead_free);
    end

    next_base = cur_base + WORD_STEP;
    last_s    = (next_base >= {1'b0, fiu});
    last_m    = (next_base >= hi);
  end

  // --------------------------------------------------------------------------
  // Mark / release of [lo, hi) within one word
  // --------------------------------------------------------------------------
  logic signed [OFF_W-1:0] lo_off;
  logic signed [OFF_W-1:0] hi_off;
  logic [WORD_BITS-1:0]    range_mask;
  logic [WORD_BITS-1:0]    mark_word;

  always_comb begin
    lo_off = OFF_W'({2'b0, lo}) - OFF_W'({1'b0, cur_base});
    hi_off = OFF_W'({1'b0, hi}) - OFF_W'({1'b0, cur_base});
    for (int b = 0; b < WORD_BITS; b++) begin
      range_mask[b] = ($signed(OFF_W'(b)) >= lo_off) && ($signed(OFF_W'(b)) < hi_off);
    end
    mark_word = (mode_r == MODE_RELEASE) ? (rd_data & ~range_mask) : (rd_data | range_mask);
  end

  // counters after a successful request
  logic [FRAME_W-1:0] free_new, os_new, hw_new;

  always_comb begin
    free_new = free_cnt;
    os_new   = os_cnt;
    hw_new   = hw_cnt;
    case (mode_r)
      MODE_ALLOC, MODE_LOCK: begin
        os_new   = sat_add(os_cnt, n_req, fiu);
        free_new = sat_sub(free_cnt, n_req);
      end
      MODE_RESERVE: begin
        hw_new   = sat_add(hw_cnt, n_req, fiu);
        free_new = sat_sub(free_cnt, n_req);
      end
      MODE_RELEASE: begin
        os_new   = sat_sub(os_cnt, n_req);
        free_new = sat_add(free_cnt, n_req, fiu);
      end
      default: begin
        free_new = free_cnt;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cur_addr;
    ram_wdata  = mark_word;
    ram_raddr  = '0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (cur_addr == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && req_valid) begin
          state_next = (req.mode == MODE_ALLOC) ? ST_SEARCH : ST_MARK;
        end
      end
      ST_SEARCH: begin
        if (hit_any) begin
          state_next = ST_MARK;      // re-read word 0 for the mark sweep
        end else if (last_s) begin
          state_next = ST_IDLE;
        end else begin
          ram_raddr = (cur_addr == LAST_WORD) ? cur_addr : cur_addr + AW'(1);
        end
      end
      ST_MARK: begin
        ram_we    = 1'b1;
        ram_raddr = (cur_addr == LAST_WORD) ? cur_addr : cur_addr + AW'(1);
        if (last_m) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_addr <= '0;
      fiu      <= FRAMES_RST;
      free_cnt <= FRAMES_RST;
      os_cnt   <= '0;
      hw_cnt   <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (cur_addr != LAST_WORD) begin
            cur_addr <= cur_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            mode_r   <= req.mode;
            first_r  <= req.first_frame;
            n_req    <= req.run_len;
            lo       <= {1'b0, req.first_frame};
            hi       <= req_end;
            cur_addr <= '0;
            cur_base <= '0;
            carry    <= '0;
            if (!req_valid) begin
              done              <= 1'b1;
              rsp.granted_frame <= (req.mode == MODE_ALLOC) ? '0 : req.first_frame;
              rsp.ok            <= 1'b0;
              rsp.free_frames   <= free_cnt;
              rsp.os_frames     <= os_cnt;
              rsp.hw_frames     <= hw_cnt;
            end
          end
        end
        ST_SEARCH: begin
          if (hit_any) begin
            lo       <= granted_c[FRAME_W-1:0];
            hi       <= granted_c + {1'b0, n_req};
            cur_addr <= '0;
            cur_base <= '0;
          end else if (last_s) begin
            done              <= 1'b1;
            rsp.granted_frame <= '0;
            rsp.ok            <= 1'b0;
            rsp.free_frames   <= free_cnt;
            rsp.os_frames     <= os_cnt;
            rsp.hw_frames     <= hw_cnt;
          end else begin
            cur_addr <= cur_addr + AW'(1);
            cur_base <= next_base;
            carry    <= carry_next;
          end
        end
        ST_MARK: begin
          if (last_m) begin
            free_cnt          <= free_new;
            os_cnt            <= os_new;
            hw_cnt            <= hw_new;
            done              <= 1'b1;
            rsp.granted_frame <= (mode_r == MODE_ALLOC) ? lo[IDX_W-1:0] : first_r;
            rsp.ok            <= 1'b1;
            rsp.free_frames   <= free_new;
            rsp.os_frames     <= os_new;
            rsp.hw_frames     <= hw_new;
          end else begin
            cur_addr <= cur_addr + AW'(1);
            cur_base <= next_base;
          end
        end
        default: begin
          cur_addr <= '0;
        end
      endcase

      // to be written only while idle; the block itself does not enforce it
      if (cfg_we) begin
        fiu      <= (cfg_data > FRAMES_MAX) ? FRAMES_MAX : cfg_data;
        free_cnt <= (cfg_data > FRAMES_MAX) ? FRAMES_MAX : cfg_data;
      end
    end
  end

endmodule

FILE: rtl/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks for the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input bfa_pkg::bfa_rsp_t rsp
);

  // an accepted word either starts work or is answered at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted request neither started nor answered");

  // responses only come out once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("response while busy");

  // every response follows either work or a request taken in the cycle before
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("response without a request");

  // an answer that needs no bitmap sweep is always a rejection
  a_fast_reject: assert property (@(posedge clk) disable iff (rst)
    done && !$past(busy) |-> !rsp.ok)
    else $error("immediate response reported success");

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bitmap_frame_allocator_core. It runs a short table
// of directed requests and register writes, then random request traffic under
// several frame limits. A predictor copy of the bitmap and the counters, or
// a response typed into the table, checks every response word field by field.
// ----------------------------------------------------------------------------
module testbench;
  import bfa_pkg::*;

  localparam int FRAMES = 4096;

  typedef struct packed {
    logic               cfg_row;   // register write instead of a request
    logic [FRAME_W-1:0] cfg_val;
    bfa_req_t           req;
    logic               pinned;    // response typed in below
    bfa_rsp_t           rsp;
  } step_t;

  typedef struct {
    int base;
    int n;
  } run_t;

  localparam bfa_rsp_t NONE = '0;

  localparam step_t DIRECTED [0:27] = '{
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd0}, 1'b1,
      '{12'd0, 1'b0, 13'd4096, 13'd0, 13'd0}},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd4097}, 1'b1,
      '{12'd0, 1'b0, 13'd4096, 13'd0, 13'd0}},
    '{1'b0, 13'd0, '{MODE_LOCK, 12'd4095, 13'd2}, 1'b1,
      '{12'd4095, 1'b0, 13'd4096, 13'd0, 13'd0}},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd1}, 1'b1,
      '{12'd0, 1'b1, 13'd4095, 13'd1, 13'd0}},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd8191}, 1'b1,
      '{12'd0, 1'b0, 13'd4095, 13'd1, 13'd0}},
    '{1'b0, 13'd0, '{MODE_RESERVE, 12'd4095, 13'd1}, 1'b1,
      '{12'd4095, 1'b1, 13'd4094, 13'd1, 13'd1}},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd4096}, 1'b1,
      '{12'd0, 1'b0, 13'd4094, 13'd1, 13'd1}},
    '{1'b0, 13'd0, '{MODE_LOCK, 12'd10, 13'd20}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd5}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd10}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_RELEASE, 12'd0, 13'd4096}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_RELEASE, 12'd0, 13'd4096}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd4096}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_LOCK, 12'd0, 13'd4096}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_RESERVE, 12'd4095, 13'd0}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_RELEASE, 12'd4095, 13'd8191}, 1'b0, NONE},
    '{1'b1, 13'd0, '{MODE_ALLOC, 12'd0, 13'd0}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd1}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_LOCK, 12'd0, 13'd1}, 1'b0, NONE},
    '{1'b1, 13'd8191, '{MODE_ALLOC, 12'd0, 13'd0}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_RELEASE, 12'd0, 13'd4096}, 1'b0, NONE},
    '{1'b1, 13'd100, '{MODE_ALLOC, 12'd0, 13'd0}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd4095, 13'd100}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd1}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_RELEASE, 12'd50, 13'd51}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_RELEASE, 12'd50, 13'd50}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd60}, 1'b0, NONE},
    '{1'b0, 13'd0, '{MODE_ALLOC, 12'd0, 13'd50}, 1'b0, NONE}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic         busy;
  bfa_req_t     req = '0;
  logic         cfg_we = 1'b0;
  logic [12:0]  cfg_data = '0;
  logic         done;
  bfa_rsp_t     rsp;

  logic         pin_valid = 1'b0;
  bfa_rsp_t     pin_rsp = '0;

  // predictor state
  logic [FRAMES-1:0] frame_used = '0;
  int frame_limit = FRAMES;
  int free_cnt = FRAMES;
  int os_cnt = 0;
  int hw_cnt = 0;

  bfa_rsp_t due_rsp [$];
  run_t     live_runs [$];
  int issued = 0;
  int answered = 0;
  int mismatch_count = 0;

  bitmap_frame_allocator_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .rsp      (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int sat_up(int c, int n);
    int s;
    s = c + n;
    return (s > frame_limit) ? frame_limit : s;
  endfunction

  function automatic int sat_down(int c, int n);
    return (n >= c) ? 0 : c - n;
  endfunction

  function automatic bfa_rsp_t serve_request(bfa_req_t r);
    bfa_rsp_t o;
    int n;
    int first;
    int run;
    int base;
    bit hit;
    n     = r.run_len;
    first = r.first_frame;
    run   = 0;
    hit   = 1'b0;
    base  = (r.mode == MODE_ALLOC) ? 0 : first;
    if (r.mode == MODE_ALLOC) begin
      if (n != 0 && n <= frame_limit) begin
        // first fit: earliest contiguous free run of n frames
        for (int f = 0; f < frame_limit && !hit; f++) begin
          if (frame_used[f]) begin
            run = 0;
          end else begin
            run++;
            if (run == n) begin
              hit  = 1'b1;
              base = f + 1 - n;
            end
          end
        end
        if (hit) begin
          for (int f = base; f < base + n; f++) frame_used[f] = 1'b1;
          os_cnt   = sat_up(os_cnt, n);
          free_cnt = sat_down(free_cnt, n);
        end
      end
    end else if (n != 0 && first + n <= frame_limit) begin
      hit = 1'b1;
      for (int f = first; f < first + n; f++) frame_used[f] = (r.mode != MODE_RELEASE);
      case (r.mode)
        MODE_LOCK: begin
          os_cnt   = sat_up(os_cnt, n);
          free_cnt = sat_down(free_cnt, n);
        end
        MODE_RESERVE: begin
          hw_cnt   = sat_up(hw_cnt, n);
          free_cnt = sat_down(free_cnt, n);
        end
        default: begin
          os_cnt   = sat_down(os_cnt, n);
          free_cnt = sat_up(free_cnt, n);
        end
      endcase
    end
    o.granted_frame = 12'(base);
    o.ok            = hit;
    o.free_frames   = 13'(free_cnt);
    o.os_frames     = 13'(os_cnt);
    o.hw_frames     = 13'(hw_cnt);
    return o;
  endfunction

  // mostly small counts, now and then anything up to cap
  function automatic int short_count(int cap);
    int top;
    top = (cap < 1) ? 1 : cap;
    if ($urandom_range(0, 7) == 0) return $urandom_range(1, top);
    return $urandom_range(1, (top < 16) ? top : 16);
  endfunction

  function automatic bfa_req_t random_request();
    bfa_req_t r;
    int pick;
    int n;
    int k;
    r.mode        = bfa_mode_t'($urandom_range(0, 3));
    r.first_frame = 12'($urandom);
    r.run_len     = 13'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10 || frame_limit == 0) return r;  // raw noise
    n = short_count(frame_limit);
    r.run_len     = 13'(n);
    r.first_frame = 12'($urandom_range(0, frame_limit - n));
    if (pick < 45) begin
      r.mode = MODE_ALLOC;
    end else if (pick < 65 && live_runs.size() != 0) begin
      k = $urandom_range(0, live_runs.size() - 1);
      r.mode        = MODE_RELEASE;
      r.first_frame = 12'(live_runs[k].base);
      r.run_len     = 13'(live_runs[k].n);
      live_runs.delete(k);
    end else if (pick < 75) begin
      r.mode = MODE_LOCK;
    end else if (pick < 85) begin
      r.mode = MODE_RESERVE;
    end else begin
      r.mode = MODE_RELEASE;
    end
    return r;
  endfunction

  function automatic int sender_gap();
    int p;
    p = $urandom_range(0, 15);
    if (p < 8) return 0;
    if (p < 15) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic issue(input bfa_req_t r, input logic pin, input bfa_rsp_t pin_r,
                       input int gap);
    start     <= 1'b1;
    req       <= r;
    pin_valid <= pin;
    pin_rsp   <= pin_r;
    do @(posedge clk); while (busy);
    issued++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every outstanding word has come back
  task automatic settle();
    start <= 1'b0;
    while (answered != issued) @(posedge clk);
  endtask

  task automatic write_limit(input logic [12:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    frame_limit = (v > FRAMES) ? FRAMES : int'(v);
    free_cnt    = frame_limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : watch
    bfa_rsp_t want;
    if (!rst) begin
      if (start && !busy) begin
        want = serve_request(req);
        if (req.mode == MODE_ALLOC && want.ok)
          live_runs.push_back(run_t'{int'(want.granted_frame), int'(req.run_len)});
        if (pin_valid) want = pin_rsp;
        due_rsp.push_back(want);
      end
      if (done) begin
        if (due_rsp.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected response word %h", rsp);
        end else begin
          want = due_rsp.pop_front();
          answered++;
          if (rsp.granted_frame !== want.granted_frame || rsp.ok !== want.ok ||
              rsp.free_frames !== want.free_frames || rsp.os_frames !== want.os_frames ||
              rsp.hw_frames !== want.hw_frames) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: want frame %0d ok %0b free %0d os %0d hw %0d, ",
                        "got frame %0d ok %0b free %0d os %0d hw %0d"},
                       want.granted_frame, want.ok, want.free_frames, want.os_frames,
                       want.hw_frames, rsp.granted_frame, rsp.ok, rsp.free_frames,
                       rsp.os_frames, rsp.hw_frames);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [12:0] limits [5];
    bfa_req_t r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg_row)
        write_limit(DIRECTED[i].cfg_val);
      else
        issue(DIRECTED[i].req, DIRECTED[i].pinned, DIRECTED[i].rsp, sender_gap());
    end

    limits = '{13'd4096, 13'd1, 13'd300, 13'($urandom_range(1, 4096)), 13'd8191};
    foreach (limits[p]) begin
      write_limit(limits[p]);
      // start each phase from an empty map
      r = '{MODE_RELEASE, 12'd0, 13'(frame_limit)};
      issue(r, 1'b0, NONE, sender_gap());
      for (int k = 0; k < 150; k++) begin
        r = random_request();
        issue(r, 1'b0, NONE, (k % 100 >= 70) ? 0 : sender_gap());
        if ($urandom_range(0, 59) == 0) settle();
      end
    end

    settle();
    repeat (150) @(posedge clk);
    if (mismatch_count == 0 && due_rsp.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: bitmap_frame_allocator_core.f
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bitmap_frame_allocator_core.sv
rtl/bfa_checker.sv
tb/sv/testbench.sv
